### hw/rtl/lfk_pkg.sv
// Shared types and constants for the leg forward kinematics unit.
// Holds the CORDIC arctangent table, the gain constant and the cell data type.
// No dependencies.
`default_nettype none

package lfk_pkg;

    localparam int CORDIC_W = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHANK = 2'd2;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd2147483648;

    // Rotation state of one angle as it moves down the cell row.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       flip;
    } lfk_rot_t;

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
        logic signed [CORDIC_W-1:0] r;
        begin
            unique case (idx)
                0: r = 34'sh020000000;  1: r = 34'sh012E4051E;
                2: r = 34'sh009FB385B;  3: r = 34'sh0051111D4;
                4: r = 34'sh0028B0D43;  5: r = 34'sh00145D7E1;
                6: r = 34'sh000A2F61E;  7: r = 34'sh000517C55;
                8: r = 34'sh00028BE53;  9: r = 34'sh000145F2F;
                10: r = 34'sh0000A2F98; 11: r = 34'sh0000517CC;
                12: r = 34'sh000028BE6; 13: r = 34'sh0000145F3;
                14: r = 34'sh00000A2FA; 15: r = 34'sh00000517D;
                16: r = 34'sh0000028BE; 17: r = 34'sh00000145F;
                18: r = 34'sh000000A30; 19: r = 34'sh000000518;
                20: r = 34'sh00000028C; 21: r = 34'sh000000146;
                22: r = 34'sh0000000A3; default: r = 34'sh000000051;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lfk_cordic_cell.sv
// One CORDIC micro-rotation cell with three lanes (yaw, hip, hip plus knee).
// Depends on lfk_pkg; carries the item valid and a stall enable.
`default_nettype none

module lfk_cordic_cell
    import lfk_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire logic     valid_in,
    input  lfk_rot_t      rot_in  [3],
    output logic          valid_out,
    output lfk_rot_t      rot_out [3]
);

    localparam logic signed [CORDIC_W-1:0] ATAN = atan_turn(STAGE);

    logic     valid_reg;
    lfk_rot_t rot_reg  [3];
    lfk_rot_t rot_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rot_next[k] = rot_in[k];
            if (!rot_in[k].z[CORDIC_W-1]) begin
                rot_next[k].x = rot_in[k].x - (rot_in[k].y >>> STAGE);
                rot_next[k].y = rot_in[k].y + (rot_in[k].x >>> STAGE);
                rot_next[k].z = rot_in[k].z - ATAN;
            end else begin
                rot_next[k].x = rot_in[k].x + (rot_in[k].y >>> STAGE);
                rot_next[k].y = rot_in[k].y - (rot_in[k].x >>> STAGE);
                rot_next[k].z = rot_in[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rot_reg <= rot_next;
        end
    end

    assign valid_out = valid_reg;
    assign rot_out   = rot_reg;

endmodule

`default_nettype wire

### hw/rtl/lfk_combine.sv
// Combines the sine and cosine results with the link lengths into the foot position.
// Three registered stages; depends on lfk_pkg.
`default_nettype none

module lfk_combine
    import lfk_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic                          valid_in,
    input  lfk_rot_t                           rot_in [3],
    input  wire logic [LENGTH_BITS-1:0]        l0,
    input  wire logic [LENGTH_BITS-1:0]        l1,
    input  wire logic [LENGTH_BITS-1:0]        l2,
    output logic                               valid_out,
    output logic signed [LENGTH_BITS+1:0]      foot_x,
    output logic signed [LENGTH_BITS+2:0]      foot_y,
    output logic signed [LENGTH_BITS+2:0]      foot_z
);

    localparam int PW = LENGTH_BITS + 17;
    localparam int BW = LENGTH_BITS + 19;
    localparam int FW = BW + 17;

    logic signed [16:0] sq [3];
    logic signed [16:0] cq [3];

    function automatic logic signed [16:0] to_q15(input logic signed [CORDIC_W-1:0] v,
                                                 input logic flip);
        logic signed [CORDIC_W:0] t;
        logic signed [CORDIC_W:0] r;
        begin
            t = flip ? -$signed({v[CORDIC_W-1], v}) : $signed({v[CORDIC_W-1], v});
            r = (t + (CORDIC_W+1)'(16384)) >>> 15;
            if (r > (CORDIC_W+1)'(32767)) r = (CORDIC_W+1)'(32767);
            if (r < -(CORDIC_W+1)'(32767)) r = -(CORDIC_W+1)'(32767);
            return r[16:0];
        end
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq[k] = to_q15(rot_in[k].y, rot_in[k].flip);
            cq[k] = to_q15(rot_in[k].x, rot_in[k].flip);
        end
    end

    // Stage 1: link products.
    logic              v1_reg, v2_reg, v3_reg;
    logic signed [PW-1:0] p1s_reg, p2s_reg, p1c_reg, p2c_reg;
    logic signed [16:0]   s0_reg, c0_reg;
    logic [LENGTH_BITS-1:0] l0_reg;
    // Stage 2: sums.
    logic signed [PW:0]   xq_reg;
    logic signed [BW-1:0] bq_reg;
    logic signed [16:0]   s0b_reg, c0b_reg;
    // Stage 3: yaw products.
    logic signed [PW:0]   xqb_reg;
    logic signed [FW-1:0] fy_reg, fz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1s_reg <= PW'($signed({1'b0, l1}) * sq[1]);
            p2s_reg <= PW'($signed({1'b0, l2}) * sq[2]);
            p1c_reg <= PW'($signed({1'b0, l1}) * cq[1]);
            p2c_reg <= PW'($signed({1'b0, l2}) * cq[2]);
            s0_reg  <= sq[0];
            c0_reg  <= cq[0];
            l0_reg  <= l0;

            xq_reg  <= -(PW+1)'(p1s_reg) - (PW+1)'(p2s_reg);
            bq_reg  <= $signed(BW'({l0_reg, 15'd0})) + BW'(p1c_reg) + BW'(p2c_reg);
            s0b_reg <= s0_reg;
            c0b_reg <= c0_reg;

            xqb_reg <= xq_reg;
            fy_reg  <= FW'(s0b_reg * bq_reg);
            fz_reg  <= -FW'(c0b_reg * bq_reg);
        end
    end

    logic signed [PW:0]   xr;
    logic signed [FW-1:0] yr, zr;

    always_comb begin
        xr = (xqb_reg + (PW+1)'(16384)) >>> 15;
        yr = (fy_reg + FW'(64'sd536870912)) >>> 30;
        zr = (fz_reg + FW'(64'sd536870912)) >>> 30;
    end

    assign valid_out = v3_reg;
    assign foot_x = xr[LENGTH_BITS+1:0];
    assign foot_y = yr[LENGTH_BITS+2:0];
    assign foot_z = zr[LENGTH_BITS+2:0];

endmodule

`default_nettype wire

### hw/rtl/leg_forward_kinematics_unit.sv
// Top level of the leg forward kinematics unit: config registers, angle
// preparation, the CORDIC cell row and the combining pipeline. Depends on lfk_pkg.
//
// channel   dir  payload
// s_axis    in   tdata: yaw_angle, hip_angle, knee_angle
// m_axis    out  tdata: foot_x, foot_y, foot_z
// cfg       in   cfg_index, cfg_data
//
// One pose per cycle while the pipe advances; a pose passes through the cell row,
// the three combining stages and the output register.
// The whole pipe advances when the output register is empty or being taken.
// Reset clears the valid bits and sets all link lengths to zero.
`default_nettype none

module leg_forward_kinematics_unit
    import lfk_pkg::*;
#(
    parameter int ANGLE_BITS  = 16,
    parameter int LENGTH_BITS = 16,
    parameter int TRIG_STAGES = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // yaw_angle, hip_angle, knee_angle from bit 0 up, zero padded
    input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // foot_x, foot_y, foot_z from bit 0 up, zero padded
    output logic [((3*LENGTH_BITS+8+7)/8)*8-1:0] m_tdata,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [LENGTH_BITS-1:0] cfg_data
);

    localparam int NST = (TRIG_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STAGES;
    localparam int MW = ((3*LENGTH_BITS+8+7)/8)*8;

    logic [LENGTH_BITS-1:0] l0_reg, l1_reg, l2_reg;
    logic advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l0_reg <= '0;
            l1_reg <= '0;
            l2_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BASE:  l0_reg <= cfg_data;
                REG_THIGH: l1_reg <= cfg_data;
                REG_SHANK: l2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Widen each angle to a 32-bit turn (the third lane adds hip to knee) and fold it into +-pi/2.
    logic [31:0] turn [3];
    lfk_rot_t    seed [3];

    always_comb begin
        turn[0] = {s_tdata[ANGLE_BITS-1:0], (32-ANGLE_BITS)'(0)};
        turn[1] = {s_tdata[2*ANGLE_BITS-1:ANGLE_BITS], (32-ANGLE_BITS)'(0)};
        turn[2] = {s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS], (32-ANGLE_BITS)'(0)} + turn[1];
        for (int k = 0; k < 3; k++) begin
            seed[k].x = CORDIC_GAIN;
            seed[k].y = '0;
            seed[k].z = CORDIC_W'($signed(turn[k]));
            seed[k].flip = 1'b0;
            if (seed[k].z > QUARTER_TURN) begin
                seed[k].z = seed[k].z - HALF_TURN;
                seed[k].flip = 1'b1;
            end else if (seed[k].z < -QUARTER_TURN) begin
                seed[k].z = seed[k].z + HALF_TURN;
                seed[k].flip = 1'b1;
            end
        end
    end

    logic     vrow [NST+1];
    lfk_rot_t rrow [NST+1][3];

    assign vrow[0] = s_tvalid;
    assign rrow[0] = seed;

    for (genvar g = 0; g < NST; g++) begin : g_cell
        lfk_cordic_cell #(.STAGE(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .valid_in (vrow[g]),
            .rot_in   (rrow[g]),
            .valid_out(vrow[g+1]),
            .rot_out  (rrow[g+1])
        );
    end

    logic comb_valid;
    logic signed [LENGTH_BITS+1:0] fx;
    logic signed [LENGTH_BITS+2:0] fy, fz;

    lfk_combine #(.LENGTH_BITS(LENGTH_BITS)) u_combine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .valid_in (vrow[NST]),
        .rot_in   (rrow[NST]),
        .l0       (l0_reg),
        .l1       (l1_reg),
        .l2       (l2_reg),
        .valid_out(comb_valid),
        .foot_x   (fx),
        .foot_y   (fy),
        .foot_z   (fz)
    );

    logic          out_valid_reg;
    logic [MW-1:0] out_data_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= comb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= MW'({fz, fy, fx});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == REG_BASE |=> l0_reg == $past(cfg_data))
        else $error("base length write lost");
`endif

endmodule

`default_nettype wire
